// ----- hdl/jlh_pkg.sv -----
// package for the lookup2 hash block: payload structs, mixer op types and the
// mix round function used by the mixer pipeline
// no dependencies
package jlh_pkg;

   localparam logic [31:0] GOLDEN_WORD    = 32'h9e3779b9;
   localparam logic [3:0]  BLOCK_LAST_POS = 4'd11;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       carries_byte;
      logic       is_last;
   } req_data_type;

   typedef struct packed {
      logic [31:0] hash_value;
      logic [31:0] bytes_hashed;
   } rsp_data_type;

   // what happens to a mix when it leaves the pipeline
   typedef enum logic [2:0] {
      KIND_BLOCK  = 3'b001,
      KIND_CHAIN  = 3'b010,
      KIND_FINISH = 3'b100
   } mix_kind_type;

   typedef struct packed {
      logic         valid;
      mix_kind_type kind;
      logic [31:0]  a;
      logic [31:0]  b;
      logic [31:0]  c;
      logic [31:0]  len;
   } mix_op_type;

   typedef struct packed {
      logic block_busy;
      logic block_done;
      logic chain_done;
      logic finish_done;
   } mix_status_type;

   typedef enum logic [1:0] {
      ROUND_FIRST  = 2'd0,
      ROUND_MIDDLE = 2'd1,
      ROUND_LAST   = 2'd2
   } mix_round_type;

   // three rows of the lookup2 mix
   function automatic mix_op_type mix_round(input mix_op_type op_in, input mix_round_type rnd);
      mix_op_type op;
      logic [4:0] sh_a;
      logic [4:0] sh_b;
      logic [4:0] sh_c;
      op = op_in;
      unique case (rnd)
         ROUND_FIRST: begin
            sh_a = 5'd13; sh_b = 5'd8;  sh_c = 5'd13;
         end
         ROUND_MIDDLE: begin
            sh_a = 5'd12; sh_b = 5'd16; sh_c = 5'd5;
         end
         ROUND_LAST: begin
            sh_a = 5'd3;  sh_b = 5'd10; sh_c = 5'd15;
         end
         default: begin
            sh_a = 5'd3;  sh_b = 5'd10; sh_c = 5'd15;
         end
      endcase
      op.a = op.a - op.b - op.c;
      op.a = op.a ^ (op.c >> sh_a);
      op.b = op.b - op.c - op.a;
      op.b = op.b ^ (op.a << sh_b);
      op.c = op.c - op.a - op.b;
      op.c = op.c ^ (op.b >> sh_c);
      return op;
   endfunction

endpackage

// ----- hdl/jenkins_lookup2_hash.sv -----
// lookup2 hash: the last item is mixed into the result register, and a block filled
// by its byte goes around the mixer again as the finish; one item per cycle, except
// that an item which fills a block or ends the message waits while an earlier block is
// in the three-stage mixer; input holds while a hash waits on a stalled result register
// synchronous active-high reset: seed 0, a and b golden word, c 0, nothing in flight
// depends on jlh_pkg, jlh_mix_pipe
module jenkins_lookup2_hash (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  jlh_pkg::req_data_type req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output jlh_pkg::rsp_data_type rsp_data,
   input  logic                  csr_write_enable,
   input  logic [31:0]           csr_write_data
);
   import jlh_pkg::*;

   logic [31:0] seed_ff, seed_in;
   logic [31:0] mix_a_ff, mix_a_in, mix_b_ff, mix_b_in, mix_c_ff, mix_c_in;
   logic [31:0] part_a_ff, part_a_in, part_b_ff, part_b_in, part_c_ff, part_c_in;
   logic [3:0]  pos_ff, pos_in;
   logic [31:0] total_len_ff, total_len_in;
   logic        msg_active_ff, msg_active_in;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_data_type rsp_data_ff, rsp_data_in;

   mix_op_type     op_in, op_out, launch_op;
   mix_status_type status;

   logic        adv, accept, block_full, needs_state, rsp_load;
   logic [31:0] byte_shifted, part_a_new, part_b_new, part_c_new, len_new;

   jlh_mix_pipe u_mix (
      .clock  (clock),
      .reset  (reset),
      .adv    (adv),
      .op_in  (op_in),
      .op_out (op_out),
      .status (status)
   );

   // the mixer only holds when a finished hash cannot move into the result register
   assign adv         = !(status.finish_done && rsp_valid_ff && rsp_stall);
   assign block_full  = req_data.carries_byte && (pos_ff == BLOCK_LAST_POS);
   assign needs_state = block_full || req_data.is_last;
   assign req_stall   = !adv || (needs_state && (status.block_busy || status.chain_done));
   assign accept      = req_valid && !req_stall;

   assign byte_shifted = {24'd0, req_data.data_byte} << {pos_ff[1:0], 3'b000};
   assign part_a_new = part_a_ff +
      ((req_data.carries_byte && (pos_ff[3:2] == 2'd0)) ? byte_shifted : 32'd0);
   assign part_b_new = part_b_ff +
      ((req_data.carries_byte && (pos_ff[3:2] == 2'd1)) ? byte_shifted : 32'd0);
   assign part_c_new = part_c_ff +
      ((req_data.carries_byte && (pos_ff[3:2] == 2'd2)) ? byte_shifted : 32'd0);
   assign len_new = total_len_ff + {31'd0, req_data.carries_byte};

   always_comb begin
      launch_op.valid = accept && needs_state;
      launch_op.a     = mix_a_ff + part_a_new;
      launch_op.b     = mix_b_ff + part_b_new;
      launch_op.len   = len_new;
      if (block_full) begin
         launch_op.kind = req_data.is_last ? KIND_CHAIN : KIND_BLOCK;
         launch_op.c    = mix_c_ff + part_c_new;
      end else begin
         launch_op.kind = KIND_FINISH;
         launch_op.c    = mix_c_ff + len_new + (part_c_new << 8);
      end
   end

   // a block filled by the last byte comes back around as the finish mix
   always_comb begin
      if (status.chain_done) begin
         op_in.valid = 1'b1;
         op_in.kind  = KIND_FINISH;
         op_in.a     = op_out.a;
         op_in.b     = op_out.b;
         op_in.c     = op_out.c + op_out.len;
         op_in.len   = op_out.len;
      end else begin
         op_in = launch_op;
      end
   end

   always_comb begin
      seed_in       = seed_ff;
      mix_a_in      = mix_a_ff;
      mix_b_in      = mix_b_ff;
      mix_c_in      = mix_c_ff;
      part_a_in     = part_a_ff;
      part_b_in     = part_b_ff;
      part_c_in     = part_c_ff;
      pos_in        = pos_ff;
      total_len_in  = total_len_ff;
      msg_active_in = msg_active_ff;

      if (status.block_done && adv) begin
         mix_a_in = op_out.a;
         mix_b_in = op_out.b;
         mix_c_in = op_out.c;
      end

      if (accept) begin
         msg_active_in = 1'b1;
         if (req_data.is_last) begin
            mix_a_in      = GOLDEN_WORD;
            mix_b_in      = GOLDEN_WORD;
            mix_c_in      = seed_ff;
            part_a_in     = 32'd0;
            part_b_in     = 32'd0;
            part_c_in     = 32'd0;
            pos_in        = 4'd0;
            total_len_in  = 32'd0;
            msg_active_in = 1'b0;
         end else if (block_full) begin
            part_a_in    = 32'd0;
            part_b_in    = 32'd0;
            part_c_in    = 32'd0;
            pos_in       = 4'd0;
            total_len_in = len_new;
         end else if (req_data.carries_byte) begin
            part_a_in    = part_a_new;
            part_b_in    = part_b_new;
            part_c_in    = part_c_new;
            pos_in       = pos_ff + 4'd1;
            total_len_in = len_new;
         end
      end

      // a new seed reaches c right away only between messages
      if (csr_write_enable) begin
         seed_in = csr_write_data;
         if (!msg_active_ff) begin
            mix_c_in = csr_write_data;
         end
      end
   end

   assign rsp_load     = status.finish_done && adv;
   assign rsp_valid_in = rsp_load || (rsp_valid_ff && rsp_stall);
   always_comb begin
      if (rsp_load) begin
         rsp_data_in.hash_value   = op_out.c;
         rsp_data_in.bytes_hashed = op_out.len;
      end else begin
         rsp_data_in = rsp_data_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff       <= 32'd0;
         mix_a_ff      <= GOLDEN_WORD;
         mix_b_ff      <= GOLDEN_WORD;
         mix_c_ff      <= 32'd0;
         part_a_ff     <= 32'd0;
         part_b_ff     <= 32'd0;
         part_c_ff     <= 32'd0;
         pos_ff        <= 4'd0;
         total_len_ff  <= 32'd0;
         msg_active_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         seed_ff       <= seed_in;
         mix_a_ff      <= mix_a_in;
         mix_b_ff      <= mix_b_in;
         mix_c_ff      <= mix_c_in;
         part_a_ff     <= part_a_in;
         part_b_ff     <= part_b_in;
         part_c_ff     <= part_c_in;
         pos_ff        <= pos_in;
         total_len_ff  <= total_len_in;
         msg_active_ff <= msg_active_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTHESIS
   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= BLOCK_LAST_POS)
      else $error("block position beyond one block");

   a_state_free: assert property (@(posedge clock) disable iff (reset)
      (accept && needs_state) |-> !status.block_busy)
      else $error("mix state used while a block mix is in flight");

   a_finish_clears: assert property (@(posedge clock) disable iff (reset)
      (accept && req_data.is_last) |=> (!msg_active_ff && (total_len_ff == 32'd0)))
      else $error("message state not restarted after finish");
`endif

endmodule

// ----- hdl/jlh_mix_pipe.sv -----
// three-stage mixer: input register, two stages of three mix rows each, and the
// last three rows in front of the consumer
// depends on jlh_pkg
module jlh_mix_pipe (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     adv,
   input  jlh_pkg::mix_op_type      op_in,
   output jlh_pkg::mix_op_type      op_out,
   output jlh_pkg::mix_status_type  status
);
   import jlh_pkg::*;

   mix_op_type s0_ff, s1_ff, s2_ff;
   mix_op_type s1_in, s2_in;

   assign s1_in  = mix_round(s0_ff, ROUND_FIRST);
   assign s2_in  = mix_round(s1_ff, ROUND_MIDDLE);
   assign op_out = mix_round(s2_ff, ROUND_LAST);

   // a block that ended its message still has to come back around as the finish
   always_comb begin
      status.block_busy  = (s0_ff.valid && (s0_ff.kind != KIND_FINISH)) ||
                           (s1_ff.valid && (s1_ff.kind != KIND_FINISH)) ||
                           (s2_ff.valid && (s2_ff.kind != KIND_FINISH));
      status.block_done  = s2_ff.valid && (s2_ff.kind == KIND_BLOCK);
      status.chain_done  = s2_ff.valid && (s2_ff.kind == KIND_CHAIN);
      status.finish_done = s2_ff.valid && (s2_ff.kind == KIND_FINISH);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_ff.valid <= 1'b0;
         s1_ff.valid <= 1'b0;
         s2_ff.valid <= 1'b0;
      end else if (adv) begin
         s0_ff <= op_in;
         s1_ff <= s1_in;
         s2_ff <= s2_in;
      end
   end

endmodule

// ----- tb/sv/jenkins_lookup2_hash_tb.sv -----
`timescale 1ns / 100ps
// self-checking testbench for jenkins_lookup2_hash: byte streams in, lookup2 hashes checked
// against a predictor held in a small scoreboard class; depends on jlh_pkg and the block's rtl

class hash_scoreboard;
   logic [31:0] seed_word;
   logic [31:0] run_a, run_b, run_c;
   logic [31:0] gather_a, gather_b, gather_c;
   logic [3:0]  byte_slot;
   logic [31:0] msg_bytes;
   bit          msg_open;
   logic [31:0] last_hash;
   jlh_pkg::rsp_data_type hashes_due[$];
   int unsigned errors;

   function new();
      errors = 0;
      last_hash = '0;
      seed_word = '0;
      open_message();
   endfunction

   function void open_message();
      run_a = jlh_pkg::GOLDEN_WORD;
      run_b = jlh_pkg::GOLDEN_WORD;
      run_c = seed_word;
      gather_a = '0;
      gather_b = '0;
      gather_c = '0;
      byte_slot = '0;
      msg_bytes = '0;
      msg_open = 1'b0;
   endfunction

   // a new seed only reaches c when no item of the message has been seen yet
   function void write_seed(logic [31:0] value);
      seed_word = value;
      if (!msg_open) run_c = value;
   endfunction

   function void scramble();
      run_a = run_a - run_b - run_c;  run_a = run_a ^ (run_c >> 13);
      run_b = run_b - run_c - run_a;  run_b = run_b ^ (run_a << 8);
      run_c = run_c - run_a - run_b;  run_c = run_c ^ (run_b >> 13);
      run_a = run_a - run_b - run_c;  run_a = run_a ^ (run_c >> 12);
      run_b = run_b - run_c - run_a;  run_b = run_b ^ (run_a << 16);
      run_c = run_c - run_a - run_b;  run_c = run_c ^ (run_b >> 5);
      run_a = run_a - run_b - run_c;  run_a = run_a ^ (run_c >> 3);
      run_b = run_b - run_c - run_a;  run_b = run_b ^ (run_a << 10);
      run_c = run_c - run_a - run_b;  run_c = run_c ^ (run_b >> 15);
   endfunction

   function void accept_item(jlh_pkg::req_data_type item);
      logic [31:0] lane;
      jlh_pkg::rsp_data_type hash;
      msg_open = 1'b1;
      if (item.carries_byte) begin
         lane = {24'd0, item.data_byte} << {byte_slot[1:0], 3'b000};
         if (byte_slot < 4) gather_a = gather_a + lane;
         else if (byte_slot < 8) gather_b = gather_b + lane;
         else gather_c = gather_c + lane;
         msg_bytes = msg_bytes + 32'd1;
         if (byte_slot == jlh_pkg::BLOCK_LAST_POS) begin
            run_a = run_a + gather_a;
            run_b = run_b + gather_b;
            run_c = run_c + gather_c;
            scramble();
            gather_a = '0;
            gather_b = '0;
            gather_c = '0;
            byte_slot = '0;
         end else begin
            byte_slot = byte_slot + 4'd1;
         end
      end
      if (item.is_last) begin
         // low byte of c belongs to the length, so the c tail sits one byte up
         run_c = run_c + msg_bytes;
         run_a = run_a + gather_a;
         run_b = run_b + gather_b;
         run_c = run_c + (gather_c << 8);
         scramble();
         hash.hash_value = run_c;
         hash.bytes_hashed = msg_bytes;
         hashes_due.push_back(hash);
         last_hash = run_c;
         open_message();
      end
   endfunction

   function void check_hash(jlh_pkg::rsp_data_type got);
      jlh_pkg::rsp_data_type want;
      if (hashes_due.size() == 0) begin
         $display("%0t: unexpected result: hash %h length %0d", $time,
                  got.hash_value, got.bytes_hashed);
         errors++;
      end else begin
         want = hashes_due.pop_front();
         if (got.hash_value !== want.hash_value) begin
            $display("%0t: hash_value mismatch: expected %h actual %h", $time,
                     want.hash_value, got.hash_value);
            errors++;
         end
         if (got.bytes_hashed !== want.bytes_hashed) begin
            $display("%0t: bytes_hashed mismatch: expected %0d actual %0d", $time,
                     want.bytes_hashed, got.bytes_hashed);
            errors++;
         end
      end
   endfunction

   function int unsigned pending();
      return hashes_due.size();
   endfunction
endclass

module jenkins_lookup2_hash_tb;
   localparam int unsigned ITEM_TARGET   = 1650;
   localparam int unsigned SETTLE_CYCLES = 10;
   localparam int unsigned IDLE_LIMIT    = 2000;

   logic                  clock;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   jlh_pkg::req_data_type req_data = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   jlh_pkg::rsp_data_type rsp_data;
   logic                  csr_write_enable = 1'b0;
   logic [31:0]           csr_write_data = '0;

   hash_scoreboard sb = new();
   int unsigned burst_left = 0;
   int unsigned items_sent = 0;
   int unsigned quiet_cycles = 0;
   int unsigned stall_cycle = 0;
   int unsigned stall_hold = 0;
   bit          stall_level = 1'b0;

   jenkins_lookup2_hash uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_data         (rsp_data),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic jlh_pkg::req_data_type make_item(logic [7:0] value, logic has_byte,
                                                       logic last);
      jlh_pkg::req_data_type item;
      item.data_byte = value;
      item.carries_byte = has_byte;
      item.is_last = last;
      return item;
   endfunction

   function automatic logic [7:0] pick_byte();
      int unsigned r;
      r = $urandom_range(0, 19);
      if (r == 0) return 8'h00;
      if (r == 1) return 8'hff;
      return 8'($urandom_range(0, 255));
   endfunction

   // sender works in bursts; a gap between bursts always drops req_valid
   task automatic send_item(input jlh_pkg::req_data_type item);
      if (burst_left == 0) begin
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(60, 300)
                                                  : $urandom_range(1, 24);
         req_valid <= 1'b0;
         repeat ($urandom_range(1, ($urandom_range(0, 7) == 0) ? 24 : 5)) @(posedge clock);
      end
      burst_left--;
      req_valid <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (req_stall);
      sb.accept_item(item);
      items_sent++;
   endtask

   task automatic send_bytes(input int unsigned count, input int unsigned idle_pct,
                             input bit last_on_final);
      for (int unsigned i = 0; i < count; i++) begin
         if ($urandom_range(0, 99) < idle_pct)
            send_item(make_item(pick_byte(), 1'b0, 1'b0));
         send_item(make_item(pick_byte(), 1'b1, last_on_final && (i == count - 1)));
      end
   endtask

   task automatic drain_hashes();
      req_valid <= 1'b0;
      burst_left = 0;
      while (sb.pending() != 0) @(posedge clock);
   endtask

   // register writes wait until every expected hash has come back and the bench has settled
   task automatic write_seed(input logic [31:0] value);
      drain_hashes();
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      sb.write_seed(value);
   endtask

   // result side: check each transfer, then pick next stall from a rotating pattern
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) sb.check_hash(rsp_data);
      stall_cycle++;
      unique case ((stall_cycle / 256) % 4)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= ($urandom_range(0, 3) == 0);
         2: rsp_stall <= ($urandom_range(0, 3) != 0);
         default: begin
            if (stall_hold == 0) begin
               stall_hold = $urandom_range(1, 20);
               stall_level = 1'($urandom_range(0, 1));
            end
            stall_hold--;
            rsp_stall <= stall_level;
         end
      endcase
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= IDLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   initial begin
      int unsigned quota;
      int unsigned phase_start;
      int unsigned len;
      int unsigned idle_pct;
      int unsigned r;
      logic [31:0] next_seed;

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty message on reset seed, then all-ones seed
      send_item(make_item(8'h00, 1'b0, 1'b1));
      write_seed(32'hffffffff);
      send_item(make_item(8'hff, 1'b0, 1'b0));
      send_item(make_item(8'hff, 1'b0, 1'b1));
      send_item(make_item(8'h00, 1'b1, 1'b1));
      send_item(make_item(8'hff, 1'b1, 1'b1));
      // last byte fills the block
      for (int unsigned i = 0; i < 12; i++)
         send_item(make_item((i % 2 == 0) ? 8'hff : 8'(i * 8'h17), 1'b1, (i == 11)));
      // tail reaching into c, closed by a separate end transfer
      for (int unsigned i = 0; i < 10; i++)
         send_item(make_item(8'(8'hf0 + i), 1'b1, 1'b0));
      send_item(make_item(8'h00, 1'b0, 1'b1));

      quota = (ITEM_TARGET - items_sent) / 6;
      for (int unsigned phase = 0; phase < 6; phase++) begin
         case (phase)
            0: next_seed = 32'h00000000;
            1: next_seed = 32'hffffffff;
            3: next_seed = sb.last_hash;
            5: next_seed = 32'h80000000;
            default: next_seed = $urandom;
         endcase
         write_seed(next_seed);
         phase_start = items_sent;
         idle_pct = (phase % 2 == 0) ? 0 : $urandom_range(5, 30);
         while (items_sent - phase_start < quota) begin
            r = $urandom_range(0, 99);
            if (r < 75) len = $urandom_range(0, 24);
            else if (r < 95) len = $urandom_range(25, 64);
            else len = $urandom_range(65, 160);
            if ((phase == 2 || phase == 4) && $urandom_range(0, 7) == 0) begin
               // seed change in mid-message must not touch the running hash
               send_bytes(len, idle_pct, 1'b0);
               write_seed($urandom);
               send_bytes($urandom_range(0, 20), idle_pct, 1'b0);
               send_item(make_item(pick_byte(), 1'b0, 1'b1));
            end else if (len != 0 && $urandom_range(0, 1) == 1) begin
               send_bytes(len, idle_pct, 1'b1);
            end else begin
               send_bytes(len, idle_pct, 1'b0);
               send_item(make_item(pick_byte(), 1'b0, 1'b1));
            end
            if (phase == 3 && $urandom_range(0, 2) == 0) drain_hashes();
         end
      end

      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (sb.errors == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end
endmodule
